// ===== rtl/gpf_pkg.sv =====
`default_nettype none
package gpf_pkg;

    // CORDIC datapath width (Q30 values with headroom)
    localparam int CW = 34;
    // width of products, sums and numerators/denominator
    localparam int VW = 38;
    // quotient magnitude bits
    localparam int QW = 33;
    // numerator magnitude after the Q16 shift
    localparam int NW = VW + 16;
    // trial divisor width
    localparam int TW = VW + QW;

    localparam logic [7:0] REG_TANGENT_LON = 8'd0;
    localparam logic [7:0] REG_TANGENT_LAT = 8'd1;

    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

    localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] OUT_MIN = 32'sh8000_0000;

    localparam logic signed [CW-1:0] ATAN_TAB [32] = '{
        34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4,
        34'sh028B0D43, 34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55,
        34'sh0028BE53, 34'sh00145F2F, 34'sh000A2F98, 34'sh000517CC,
        34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA, 34'sh0000517D,
        34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
        34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051,
        34'sh00000029, 34'sh00000014, 34'sh0000000A, 34'sh00000005,
        34'sh00000003, 34'sh00000001, 34'sh00000001, 34'sh00000000
    };

    typedef struct packed {
        logic [QW-1:0] mag_x;
        logic [QW-1:0] mag_y;
        logic          ovf_x;
        logic          ovf_y;
        logic          neg_x;
        logic          neg_y;
        logic          zero_x;
        logic          zero_y;
        logic          den_nonpos;
    } div_res_t;

    // Q30 product, floored
    function automatic logic signed [VW-1:0] mul30(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
        logic signed [2*VW-1:0] p;
        p = a * b;
        return p[VW+29:30];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gpf_if.sv =====
`default_nettype none
interface gpf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] point_lon;
    logic [31:0] point_lat;
    modport source (output valid, output point_lon, output point_lat, input ready);
    modport sink (input valid, input point_lon, input point_lat, output ready);
endinterface

interface gpf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] plane_x;
    logic [31:0] plane_y;
    logic        out_of_range;
    modport source (output valid, output plane_x, output plane_y, output out_of_range,
                    input ready);
    modport sink (input valid, input plane_x, input plane_y, input out_of_range,
                  output ready);
endinterface

interface gpf_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/gnomonic_forward_projection.sv =====
`default_nettype none
// Gnomonic forward projection. Each transaction on point carries a longitude and
// latitude (32-bit binary angles) and produces one transaction on plane with the
// Q16.16 coordinates on the plane tangent at (tangent_lon, tangent_lat), saturated,
// with out_of_range set beyond the horizon or on saturation. The datapath is a
// single pipeline that accepts one transaction per cycle unless plane stalls;
// it runs through the three parallel sine/cosine units, the products and sums,
// the bit-per-stage divider and one output register. The whole pipeline halts
// while a result waits on plane, so point.ready follows the output side.
// Registers are written through cfg, which is always ready; write them only
// while the pipeline is empty.
module gnomonic_forward_projection #(
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gpf_in_if.sink     point,
    gpf_out_if.source  plane,
    gpf_cfg_if.sink    cfg
);
    import gpf_pkg::*;

    localparam int L = CORDIC_STAGES + 1 + 3 + QW + 1;

    logic [31:0] tlon_reg;
    logic [31:0] tlat_reg;
    logic        en;
    logic [L-1:0] vld_reg;
    logic [L-1:0] ident_reg;

    logic signed [CW-1:0] sl, cl, st, ct, sd, cd;
    logic signed [VW-1:0] sl1_reg, cl1_reg, st1_reg, ct1_reg, sd1_reg, clcd1_reg;
    logic signed [VW-1:0] p_ss_reg, p_cc_reg, p_x_reg, p_cs_reg, p_sc_reg;
    logic signed [VW-1:0] den_reg, nx_reg, ny_reg;
    div_res_t             dres;

    logic        out_valid_reg;
    logic [31:0] x_reg, y_reg;
    logic        oor_reg;
    logic [31:0] x_next, y_next;
    logic        oor_next;
    logic        ident_next;

    assign en          = !out_valid_reg || plane.ready;
    assign point.ready = en;
    assign cfg.ready   = 1'b1;
    assign ident_next  = (point.point_lon == tlon_reg) && (point.point_lat == tlat_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlon_reg <= '0;
            tlat_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TANGENT_LON: tlon_reg <= cfg.data;
                REG_TANGENT_LAT: tlat_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    gpf_cordic #(.STAGES(CORDIC_STAGES)) u_cor_lat (
        .clk(clk), .en(en), .ang(point.point_lat), .sin_q30(sl), .cos_q30(cl)
    );
    gpf_cordic #(.STAGES(CORDIC_STAGES)) u_cor_tlat (
        .clk(clk), .en(en), .ang(tlat_reg), .sin_q30(st), .cos_q30(ct)
    );
    gpf_cordic #(.STAGES(CORDIC_STAGES)) u_cor_dlon (
        .clk(clk), .en(en), .ang(point.point_lon - tlon_reg), .sin_q30(sd), .cos_q30(cd)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sl1_reg   <= VW'(sl);
            cl1_reg   <= VW'(cl);
            st1_reg   <= VW'(st);
            ct1_reg   <= VW'(ct);
            sd1_reg   <= VW'(sd);
            clcd1_reg <= mul30(VW'(cl), VW'(cd));
            p_ss_reg  <= mul30(st1_reg, sl1_reg);
            p_cc_reg  <= mul30(ct1_reg, clcd1_reg);
            p_x_reg   <= mul30(cl1_reg, sd1_reg);
            p_cs_reg  <= mul30(ct1_reg, sl1_reg);
            p_sc_reg  <= mul30(st1_reg, clcd1_reg);
            den_reg   <= p_ss_reg + p_cc_reg;
            nx_reg    <= p_x_reg;
            ny_reg    <= p_cs_reg - p_sc_reg;
        end
    end

    gpf_divider u_div (
        .clk(clk), .en(en), .num_x(nx_reg), .num_y(ny_reg), .den(den_reg), .res(dres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            ident_reg <= '0;
        end
        else if (en)
        begin
            vld_reg   <= {vld_reg[L-2:0], point.valid};
            ident_reg <= {ident_reg[L-2:0], ident_next};
        end
    end

    always_comb
    begin
        logic ox;
        logic oy;
        ox = 1'b0;
        oy = 1'b0;
        if (dres.den_nonpos)
        begin
            x_next = dres.zero_x ? 32'd0 : (dres.neg_x ? OUT_MIN : OUT_MAX);
            y_next = dres.zero_y ? 32'd0 : (dres.neg_y ? OUT_MIN : OUT_MAX);
            ox     = 1'b1;
        end
        else
        begin
            if (!dres.neg_x)
            begin
                ox     = dres.ovf_x || (dres.mag_x > QW'(OUT_MAX));
                x_next = ox ? OUT_MAX : dres.mag_x[31:0];
            end
            else
            begin
                ox     = dres.ovf_x || (dres.mag_x > (QW'(1) << 31));
                x_next = ox ? OUT_MIN : 32'(-dres.mag_x);
            end
            if (!dres.neg_y)
            begin
                oy     = dres.ovf_y || (dres.mag_y > QW'(OUT_MAX));
                y_next = oy ? OUT_MAX : dres.mag_y[31:0];
            end
            else
            begin
                oy     = dres.ovf_y || (dres.mag_y > (QW'(1) << 31));
                y_next = oy ? OUT_MIN : 32'(-dres.mag_y);
            end
        end
        oor_next = ox | oy;
        // a point on the tangent point itself maps to the origin
        if (ident_reg[L-1])
        begin
            x_next   = '0;
            y_next   = '0;
            oor_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld_reg[L-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            oor_reg <= oor_next;
        end
    end

    assign plane.valid        = out_valid_reg;
    assign plane.plane_x      = x_reg;
    assign plane.plane_y      = y_reg;
    assign plane.out_of_range = oor_reg;

endmodule
`default_nettype wire

// ===== rtl/gpf_cordic.sv =====
`default_nettype none
module gpf_cordic #(
    parameter int STAGES = 24
) (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [31:0]                    ang,
    output logic signed [gpf_pkg::CW-1:0]       sin_q30,
    output logic signed [gpf_pkg::CW-1:0]       cos_q30
);
    import gpf_pkg::*;

    logic signed [CW-1:0] x_reg [STAGES+1];
    logic signed [CW-1:0] y_reg [STAGES+1];
    logic signed [CW-1:0] z_reg [STAGES+1];
    logic                 flip_reg [STAGES+1];

    logic        flip_next;
    logic [31:0] a_next;

    // fold the outer quadrants by a half turn
    assign flip_next = ang[31] ^ ang[30];
    assign a_next    = flip_next ? (ang ^ 32'h8000_0000) : ang;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= CW'(signed'(a_next));
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    assign cos_q30 = flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
    assign sin_q30 = flip_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];

endmodule
`default_nettype wire

// ===== rtl/gpf_divider.sv =====
`default_nettype none
module gpf_divider (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic signed [gpf_pkg::VW-1:0] num_x,
    input  wire logic signed [gpf_pkg::VW-1:0] num_y,
    input  wire logic signed [gpf_pkg::VW-1:0] den,
    output gpf_pkg::div_res_t                 res
);
    import gpf_pkg::*;

    logic [NW-1:0] rx_reg [QW+1];
    logic [NW-1:0] ry_reg [QW+1];
    logic [QW-1:0] qx_reg [QW+1];
    logic [QW-1:0] qy_reg [QW+1];
    logic [VW-1:0] d_reg [QW+1];
    div_res_t      fl_reg [QW+1];

    logic [VW-1:0] mag_x;
    logic [VW-1:0] mag_y;
    logic [NW-1:0] nx_sh;
    logic [NW-1:0] ny_sh;
    logic [VW-1:0] d_next;
    logic          nonpos;
    div_res_t      fl_next;

    assign mag_x  = num_x[VW-1] ? VW'(-num_x) : VW'(num_x);
    assign mag_y  = num_y[VW-1] ? VW'(-num_y) : VW'(num_y);
    assign nx_sh  = {mag_x, 16'd0};
    assign ny_sh  = {mag_y, 16'd0};
    assign nonpos = den[VW-1] | (den == '0);
    assign d_next = nonpos ? VW'(1) : VW'(den);

    // anything at or above the divisor times 2^QW cannot be represented
    always_comb
    begin
        fl_next            = '0;
        fl_next.ovf_x      = TW'(nx_sh) >= (TW'(d_next) << QW);
        fl_next.ovf_y      = TW'(ny_sh) >= (TW'(d_next) << QW);
        fl_next.neg_x      = num_x[VW-1];
        fl_next.neg_y      = num_y[VW-1];
        fl_next.zero_x     = (num_x == '0);
        fl_next.zero_y     = (num_y == '0);
        fl_next.den_nonpos = nonpos;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0] <= nx_sh;
            ry_reg[0] <= ny_sh;
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            d_reg[0]  <= d_next;
            fl_reg[0] <= fl_next;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_bit
        localparam int K = QW - 1 - j;
        logic [TW-1:0] trial;
        logic          take_x;
        logic          take_y;
        assign trial  = TW'(d_reg[j]) << K;
        assign take_x = TW'(rx_reg[j]) >= trial;
        assign take_y = TW'(ry_reg[j]) >= trial;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[j+1] <= take_x ? NW'(TW'(rx_reg[j]) - trial) : rx_reg[j];
                ry_reg[j+1] <= take_y ? NW'(TW'(ry_reg[j]) - trial) : ry_reg[j];
                qx_reg[j+1] <= qx_reg[j] | (QW'(take_x) << K);
                qy_reg[j+1] <= qy_reg[j] | (QW'(take_y) << K);
                d_reg[j+1]  <= d_reg[j];
                fl_reg[j+1] <= fl_reg[j];
            end
        end
    end

    always_comb
    begin
        res       = fl_reg[QW];
        res.mag_x = qx_reg[QW];
        res.mag_y = qy_reg[QW];
    end

endmodule
`default_nettype wire

// ===== rtl/gpf_checker.sv =====
`default_nettype none
module gpf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        point_ready,
    input wire logic        plane_valid,
    input wire logic        plane_ready,
    input wire logic [31:0] plane_x,
    input wire logic [31:0] plane_y,
    input wire logic        plane_oor,
    input wire logic        cfg_ready
);
    // the pipeline moves exactly when the output register can be freed
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        point_ready == (!plane_valid || plane_ready))
        else $error("input ready does not follow output side");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        plane_valid && !plane_ready |=> plane_valid && $stable(plane_x)
            && $stable(plane_y) && $stable(plane_oor))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port not ready");
endmodule

bind gnomonic_forward_projection gpf_checker u_gpf_checker (
    .clk(clk),
    .rst_n(rst_n),
    .point_ready(point.ready),
    .plane_valid(plane.valid),
    .plane_ready(plane.ready),
    .plane_x(plane.plane_x),
    .plane_y(plane.plane_y),
    .plane_oor(plane.out_of_range),
    .cfg_ready(cfg.ready)
);
`default_nettype wire
